// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Clock clk, synchronous reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cee_pkg.sv -----
`default_nettype none

package cee_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CNT_W = 64;
  localparam int EXP_W = 42;
  localparam int IP_W = 7;
  localparam int SERIES_TERMS = 12;
  localparam int DIV_SHIFT = 8 + FRAC_BITS;

  localparam logic signed [EXP_W-1:0] EXP_BASE = EXP_W'(FRAC_BITS) << 34;
  localparam logic signed [EXP_W-1:0] SLOPE_K = EXP_W'(22293082);
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] Q30_ONE = 31'd1 << 30;
  localparam logic [27:0] BASE_COUNT = 28'd200000000;

  localparam logic [1:0] REG_PSF_WIDTH = 2'd0;
  localparam logic [1:0] REG_SYS_ERROR = 2'd1;
  localparam logic [1:0] REG_BG_MAG = 2'd2;
  localparam logic [1:0] REG_PIX_COUNT = 2'd3;

  // Exact reciprocal for floor(x / n), x below 2^30: (x * mul) >> shift.
  function automatic logic [30:0] recip_mul(input int n);
    logic [30:0] m;
    case (n)
      1, 2, 4, 8: m = 31'd1073741824;
      3, 6, 12: m = 31'd1431655766;
      5, 10: m = 31'd1717986919;
      7: m = 31'd1227133514;
      9: m = 31'd1908874354;
      11: m = 31'd1561806290;
      default: m = 31'd0;
    endcase
    return m;
  endfunction

  function automatic int recip_shift(input int n);
    int s;
    case (n)
      1: s = 30;
      2: s = 31;
      3, 4: s = 32;
      5, 6, 7, 8: s = 33;
      default: s = 34;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cee_photon.sv -----
`default_nettype none

module cee_photon (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic signed [15:0] magnitude,
  output logic        out_valid,
  output logic [cee_pkg::CNT_W-1:0] count
);

  localparam int N = cee_pkg::SERIES_TERMS;
  localparam int EW = cee_pkg::EXP_W;
  localparam int IW = cee_pkg::IP_W;

  logic                 v0;
  logic signed [EW-1:0] e0;
  logic signed [EW-1:0] mag_ext;
  logic signed [EW-1:0] e_next;
  logic [53:0]          y_prod;

  logic          v_b    [0:N];
  logic [30:0]   term_b [0:N];
  logic [31:0]   sum_b  [0:N];
  logic [29:0]   y_b    [0:N];
  logic [IW-1:0] ip_b   [0:N];
  logic          zero_b [0:N];

  logic          v_a    [1:N];
  logic [29:0]   p_a    [1:N];
  logic [31:0]   sum_a  [1:N];
  logic [29:0]   y_a    [1:N];
  logic [IW-1:0] ip_a   [1:N];
  logic          zero_a [1:N];

  logic          v_m;
  logic [59:0]   x_m;
  logic [IW-1:0] ip_m;
  logic          zero_m;

  logic          v_o;
  logic [63:0]   count_o;
  logic [63:0]   count_next;
  logic [IW-1:0] sh_l;
  logic [127:0]  wide;

  assign mag_ext = EW'(magnitude);
  assign e_next  = cee_pkg::EXP_BASE - mag_ext * cee_pkg::SLOPE_K;
  assign y_prod  = 54'(e0[33:10]) * 54'(cee_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v_b[0] <= 1'b0;
    end else if (en) begin
      v0     <= in_valid;
      v_b[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0        <= e_next;
      y_b[0]    <= y_prod[53:24];
      term_b[0] <= cee_pkg::Q30_ONE;
      sum_b[0]  <= 32'(cee_pkg::Q30_ONE);
      ip_b[0]   <= e0[EW-2:34];
      zero_b[0] <= e0[EW-1];
    end
  end

  // Taylor series of 2^f: one multiply stage and one divide-by-n stage per term.
  for (genvar k = 1; k <= N; k++) begin : g_term
    logic [59:0] prod_a;
    logic [60:0] prod_b;
    logic [30:0] q;

    assign prod_a = 60'(term_b[k-1]) * 60'(y_b[k-1]);
    assign prod_b = 61'(p_a[k]) * 61'(cee_pkg::recip_mul(k));
    assign q      = 31'(prod_b >> cee_pkg::recip_shift(k));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[k] <= 1'b0;
        v_b[k] <= 1'b0;
      end else if (en) begin
        v_a[k] <= v_b[k-1];
        v_b[k] <= v_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_a[k]    <= prod_a[59:30];
        sum_a[k]  <= sum_b[k-1];
        y_a[k]    <= y_b[k-1];
        ip_a[k]   <= ip_b[k-1];
        zero_a[k] <= zero_b[k-1];
        term_b[k] <= q;
        sum_b[k]  <= sum_a[k] + 32'(q);
        y_b[k]    <= y_a[k];
        ip_b[k]   <= ip_a[k];
        zero_b[k] <= zero_a[k];
      end
    end
  end

  // Scale the mantissa and shift it into place, clipping at the top.
  assign sh_l = ip_m - IW'(30);
  assign wide = 128'(x_m) << sh_l;

  always_comb begin
    if (zero_m) begin
      count_next = '0;
    end else if (ip_m >= IW'(30)) begin
      if (wide[127:64] != '0) begin
        count_next = '1;
      end else begin
        count_next = wide[63:0];
      end
    end else begin
      count_next = 64'(x_m >> (IW'(30) - ip_m));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
      v_o <= 1'b0;
    end else if (en) begin
      v_m <= v_b[N];
      v_o <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_m     <= 60'(sum_b[N]) * 60'(cee_pkg::BASE_COUNT);
      ip_m    <= ip_b[N];
      zero_m  <= zero_b[N];
      count_o <= count_next;
    end
  end

  assign out_valid = v_o;
  assign count     = count_o;

endmodule

`default_nettype wire

// ----- rtl/cee_divide.sv -----
`default_nettype none

module cee_divide (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] tot,
  input  logic [63:0] star,
  input  logic [31:0] psf_sq,
  output logic        out_valid,
  output logic [63:0] quot,
  output logic        out_sat
);

  localparam int STEPS = 64;

  logic        v0, v1;
  logic [63:0] pt0, pt1, s00, s01, s11;
  logic        zero0, zero1;
  logic [127:0] n1, d1;
  logic [95:0]  num96;

  logic         v_s    [0:STEPS];
  logic [127:0] r_s    [0:STEPS];
  logic [63:0]  nq_s   [0:STEPS];
  logic [127:0] d_s    [0:STEPS];
  logic         over_s [0:STEPS];

  assign num96 = 96'(pt0) + (96'(pt1) << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v1     <= 1'b0;
      v_s[0] <= 1'b0;
    end else if (en) begin
      v0     <= in_valid;
      v1     <= v0;
      v_s[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt0       <= 64'(tot[31:0]) * 64'(psf_sq);
      pt1       <= 64'(tot[63:32]) * 64'(psf_sq);
      s00       <= 64'(star[31:0]) * 64'(star[31:0]);
      s01       <= 64'(star[31:0]) * 64'(star[63:32]);
      s11       <= 64'(star[63:32]) * 64'(star[63:32]);
      zero0     <= (star == '0);
      n1        <= 128'(num96) << cee_pkg::DIV_SHIFT;
      d1        <= 128'(s00) + (128'(s01) << 33) + (128'(s11) << 64);
      zero1     <= zero0;
      // Quotient needs more than 64 bits when the upper numerator half reaches d.
      over_s[0] <= zero1 || (128'(n1[127:64]) >= d1);
      r_s[0]    <= 128'(n1[127:64]);
      nq_s[0]   <= n1[63:0];
      d_s[0]    <= d1;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= STEPS; k++) begin : g_div
    logic [128:0] rr;
    logic         ge;

    assign rr = {r_s[k-1], nq_s[k-1][63]};
    assign ge = (rr >= {1'b0, d_s[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k]    <= ge ? 128'(rr - {1'b0, d_s[k-1]}) : rr[127:0];
        nq_s[k]   <= {nq_s[k-1][62:0], ge};
        d_s[k]    <= d_s[k-1];
        over_s[k] <= over_s[k-1];
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign quot      = nq_s[STEPS];
  assign out_sat   = over_s[STEPS];

endmodule

`default_nettype wire

// ----- rtl/cee_sqrt.sv -----
`default_nettype none

module cee_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  input  logic        in_sat,
  input  logic [39:0] sys_sq,
  output logic        out_valid,
  output logic [31:0] root,
  output logic        out_sat
);

  localparam int STEPS = 32;

  logic [64:0] sum65;

  logic        v_s   [0:STEPS];
  logic [63:0] val_s [0:STEPS];
  logic [33:0] rem_s [0:STEPS];
  logic [31:0] rt_s  [0:STEPS];
  logic        sat_s [0:STEPS];

  assign sum65 = 65'(radicand) + 65'(sys_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_s[0] <= sum65[63:0];
      rem_s[0] <= '0;
      rt_s[0]  <= '0;
      sat_s[0] <= in_sat | sum65[64];
    end
  end

  // Digit-by-digit square root, one root bit per stage.
  for (genvar k = 1; k <= STEPS; k++) begin : g_root
    logic [35:0] rr;
    logic [35:0] trial;
    logic        ge;

    assign rr    = {rem_s[k-1], val_s[k-1][63:62]};
    assign trial = {2'b00, rt_s[k-1], 2'b01};
    assign ge    = (rr >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? 34'(rr - trial) : 34'(rr);
        rt_s[k]  <= {rt_s[k-1][30:0], ge};
        val_s[k] <= {val_s[k-1][61:0], 2'b00};
        sat_s[k] <= sat_s[k-1];
      end
    end
  end

  assign out_valid = v_s[STEPS];
  assign root      = rt_s[STEPS];
  assign out_sat   = sat_s[STEPS];

endmodule

`default_nettype wire

// ----- rtl/centroid_error_estimator.sv -----
// Centroid error estimator: takes one star magnitude per beat (1/1024 mag) and
// returns the one-sigma centroid error in 1/65536 pixel, with saturated set when
// the value is clipped to all ones (zero star count or a variance beyond 64 bits).
// The block is fully pipelined: it accepts one beat every cycle unless stalled.
// The pipeline includes the 64-stage restoring divider (one quotient bit per
// stage), the 32-stage square root and the 12-term series for 2^x, which runs
// as a multiply stage and a reciprocal-divide stage per term. A stall on the
// result side while a result is valid freezes the whole pipeline; the result
// register holds, and star_stall rises only in that cycle.
// Configuration writes are taken every cycle (cfg_ready is always high) and must
// only be issued while no beat is in flight.
`default_nettype none
`include "assert_macros.svh"

module centroid_error_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        star_valid,
  output logic        star_stall,
  input  logic signed [15:0] star_magnitude,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] centroid_sigma,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        en;

  // Configuration registers.
  logic [15:0]        psf_width;
  logic [15:0]        systematic_error;
  logic signed [15:0] background_magnitude;
  logic [10:0]        pixel_count;

  // Squares of the PSF width and the scaled systematic error, refreshed every cycle from the registers.
  logic [31:0] psf_sq;
  logic [39:0] sys_sq;

  logic        star_cnt_valid, bg_cnt_valid;
  logic [63:0] star_count, bg_count;

  logic        v_t0, v_t1;
  logic [63:0] star_t0, star_t1, bk_scaled, tot;
  logic [74:0] bk_prod;
  logic [64:0] tot65;

  logic        div_valid, div_sat;
  logic [63:0] quot;

  logic [31:0] root;
  logic        root_sat;

  // Advance every stage unless a finished result is being held.
  assign en         = !(result_valid && result_stall);
  assign star_stall = !en;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      psf_width            <= 16'd4096;
      systematic_error     <= 16'd0;
      background_magnitude <= 16'sd18432;
      pixel_count          <= 11'd9;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cee_pkg::REG_PSF_WIDTH: psf_width            <= cfg_data;
        cee_pkg::REG_SYS_ERROR: systematic_error     <= cfg_data;
        cee_pkg::REG_BG_MAG:    background_magnitude <= cfg_data;
        cee_pkg::REG_PIX_COUNT: pixel_count          <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    psf_sq <= 32'(psf_width) * 32'(psf_width);
    sys_sq <= 40'({systematic_error, 4'b0000}) * 40'({systematic_error, 4'b0000});
  end

  // Star and background counts run in lockstep through identical pipelines.
  cee_photon u_star (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (star_valid),
    .magnitude (star_magnitude),
    .out_valid (star_cnt_valid),
    .count     (star_count)
  );

  cee_photon u_bg (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (star_valid),
    .magnitude (background_magnitude),
    .out_valid (bg_cnt_valid),
    .count     (bg_count)
  );

  // Scale the background by the pixel count, then form the total; both clip.
  assign bk_prod = 75'(bg_count) * 75'(pixel_count);
  assign tot65   = 65'(star_t0) + 65'(bk_scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t0 <= 1'b0;
      v_t1 <= 1'b0;
    end else if (en) begin
      v_t0 <= star_cnt_valid;
      v_t1 <= v_t0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bk_scaled <= (bk_prod[74:64] != '0) ? '1 : bk_prod[63:0];
      star_t0   <= star_count;
      tot       <= tot65[64] ? '1 : tot65[63:0];
      star_t1   <= star_t0;
    end
  end

  // Statistical variance: tot * psf^2 * 2^(8+frac) / star^2.
  cee_divide u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_t1),
    .tot       (tot),
    .star      (star_t1),
    .psf_sq    (psf_sq),
    .out_valid (div_valid),
    .quot      (quot),
    .out_sat   (div_sat)
  );

  // Add the systematic term in quadrature and take the root.
  cee_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .radicand  (quot),
    .in_sat    (div_sat),
    .sys_sq    (sys_sq),
    .out_valid (result_valid),
    .root      (root),
    .out_sat   (root_sat)
  );

  assign centroid_sigma = root_sat ? '1 : root;
  assign saturated      = root_sat;

  `ASSERT_ALWAYS(a_lane_sync, star_cnt_valid == bg_cnt_valid)
  `ASSERT_IMPLIES(a_sat_max, result_valid && saturated, centroid_sigma == '1)
  `ASSERT_IMPLIES(a_sys_floor, result_valid && !saturated,
                  centroid_sigma >= {12'b0, systematic_error, 4'b0000})

endmodule

`default_nettype wire
